>>> design/label_bounding_box_tracker_top_macros.svh
// assertion macros for the label bounding box tracker
`ifndef LABEL_BOUNDING_BOX_TRACKER_TOP_MACROS_SVH
`define LABEL_BOUNDING_BOX_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LBBT_ASSERT_SAME(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);
`define LBBT_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LBBT_ASSERT_SAME(name, clock, resetn, ante, cons, msg)
`define LBBT_ASSERT_NEXT(name, clock, resetn, ante, cons, msg)
`endif

`endif

>>> design/lbbt_pkg.sv
// shared constants and types of the label bounding box tracker
package lbbt_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int COORD_W_DEFAULT = $clog2(MAX_DIM_DEFAULT);
    localparam int PIXEL_W = 8;
    localparam int CFG_W = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int LABEL_COUNT = 5;
    localparam int LABEL_IDX_W = $clog2(LABEL_COUNT);

    localparam logic [PIXEL_W-1:0] LABEL_FIRST = 8'd201;
    localparam logic [PIXEL_W-1:0] LABEL_NONE = 8'd0;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 13'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // registered pixel word status
    typedef struct packed {
        logic valid;
        logic frame_end;
    } px_ctrl_t;

    // drain sequencer status toward raster and store
    typedef struct packed {
        logic                   busy;
        logic [LABEL_COUNT-1:0] clear;
    } drain_ctrl_t;

endpackage

>>> design/lbbt_ifs.sv
// pixel and box channel interfaces
interface lbbt_pixel_if;
    import lbbt_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface lbbt_box_if #(
    parameter int CW = lbbt_pkg::COORD_W_DEFAULT
);
    import lbbt_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] label;
    logic [CW-1:0]      box_x;
    logic [CW-1:0]      box_y;
    logic [CW:0]        box_width;
    logic [CW:0]        box_height;
    logic               found;
    logic               last;

    modport source (
        output valid, output label, output box_x, output box_y,
        output box_width, output box_height, output found, output last,
        input ready
    );
    modport sink (
        input valid, input label, input box_x, input box_y,
        input box_width, input box_height, input found, input last,
        output ready
    );
endinterface

>>> design/lbbt_raster.sv
// size registers, raster counters and pixel input register
module lbbt_raster #(
    parameter int MAX_DIM = lbbt_pkg::MAX_DIM_DEFAULT,
    parameter int CW = $clog2(MAX_DIM)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [lbbt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lbbt_pkg::CFG_W-1:0]        cfg_data,
    lbbt_pixel_if.sink                        pixels,
    input  lbbt_pkg::drain_ctrl_t             drain,
    output lbbt_pkg::px_ctrl_t                px,
    output logic [lbbt_pkg::PIXEL_W-1:0]      px_pixel,
    output logic [CW-1:0]                     px_col,
    output logic [CW-1:0]                     px_row
);
    import lbbt_pkg::*;

    localparam int SW = CW + 1;
    localparam int CMPW = (CFG_W > SW) ? CFG_W : SW;

    logic [CFG_W-1:0]   width_reg, width_next;
    logic [CFG_W-1:0]   height_reg, height_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [CW-1:0]      row_reg, row_next;
    px_ctrl_t           px_reg, px_next;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [CW-1:0]      px_col_reg;
    logic [CW-1:0]      px_row_reg;

    logic [CMPW-1:0] width_ext;
    logic [CMPW-1:0] height_ext;
    logic [SW-1:0]   width_eff;
    logic [SW-1:0]   height_eff;
    logic            row_end;
    logic            frame_end;
    logic            accept;

    always_comb
    begin
        width_ext = CMPW'(width_reg);
        height_ext = CMPW'(height_reg);
        if (width_ext == '0)
            width_eff = SW'(1);
        else if (width_ext > CMPW'(MAX_DIM))
            width_eff = SW'(MAX_DIM);
        else
            width_eff = SW'(width_ext);
        if (height_ext == '0)
            height_eff = SW'(1);
        else if (height_ext > CMPW'(MAX_DIM))
            height_eff = SW'(MAX_DIM);
        else
            height_eff = SW'(height_ext);
    end

    assign row_end = (SW'(col_reg) + SW'(1)) >= width_eff;
    assign frame_end = row_end && ((SW'(row_reg) + SW'(1)) >= height_eff);

    // hold off while the last pixel of a frame is still ahead of the drain and while the drain is busy
    assign pixels.ready = !(px_reg.valid && px_reg.frame_end) && !drain.busy;
    assign accept = pixels.valid && pixels.ready;

    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        if (cfg_wen)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_next = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                    row_next = '0;
                else
                    row_next = row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        px_next.valid = accept;
        px_next.frame_end = accept && frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            px_reg <= '0;
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
            col_reg <= col_next;
            row_reg <= row_next;
            px_reg <= px_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg <= pixels.pixel;
            px_col_reg <= col_reg;
            px_row_reg <= row_reg;
        end
    end

    assign px = px_reg;
    assign px_pixel = pixel_reg;
    assign px_col = px_col_reg;
    assign px_row = px_row_reg;
endmodule

>>> design/lbbt_store.sv
// per label seen flags and min / max extents
module lbbt_store #(
    parameter int CW = lbbt_pkg::COORD_W_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lbbt_pkg::px_ctrl_t                 px,
    input  logic [lbbt_pkg::PIXEL_W-1:0]       px_pixel,
    input  logic [CW-1:0]                      px_col,
    input  logic [CW-1:0]                      px_row,
    input  lbbt_pkg::drain_ctrl_t              drain,
    output logic [lbbt_pkg::LABEL_COUNT-1:0]   seen,
    output logic [CW-1:0]                      min_col [lbbt_pkg::LABEL_COUNT],
    output logic [CW-1:0]                      max_col [lbbt_pkg::LABEL_COUNT],
    output logic [CW-1:0]                      min_row [lbbt_pkg::LABEL_COUNT],
    output logic [CW-1:0]                      max_row [lbbt_pkg::LABEL_COUNT]
);
    import lbbt_pkg::*;

    logic [LABEL_COUNT-1:0] seen_reg, seen_next;
    logic [CW-1:0]          min_col_reg [LABEL_COUNT];
    logic [CW-1:0]          max_col_reg [LABEL_COUNT];
    logic [CW-1:0]          min_row_reg [LABEL_COUNT];
    logic [CW-1:0]          max_row_reg [LABEL_COUNT];
    logic [CW-1:0]          min_col_next [LABEL_COUNT];
    logic [CW-1:0]          max_col_next [LABEL_COUNT];
    logic [CW-1:0]          min_row_next [LABEL_COUNT];
    logic [CW-1:0]          max_row_next [LABEL_COUNT];
    logic [LABEL_COUNT-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < LABEL_COUNT; k++)
        begin
            hit[k] = px.valid && (px_pixel == LABEL_FIRST + PIXEL_W'(k));
            seen_next[k] = seen_reg[k];
            min_col_next[k] = min_col_reg[k];
            max_col_next[k] = max_col_reg[k];
            min_row_next[k] = min_row_reg[k];
            max_row_next[k] = max_row_reg[k];
            if (drain.clear[k])
            begin
                seen_next[k] = 1'b0;
            end
            else if (hit[k])
            begin
                seen_next[k] = 1'b1;
                // first hit loads the extents from the current position
                if (!seen_reg[k] || px_col < min_col_reg[k])
                    min_col_next[k] = px_col;
                if (!seen_reg[k] || px_col > max_col_reg[k])
                    max_col_next[k] = px_col;
                if (!seen_reg[k] || px_row < min_row_reg[k])
                    min_row_next[k] = px_row;
                if (!seen_reg[k] || px_row > max_row_reg[k])
                    max_row_next[k] = px_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else
            seen_reg <= seen_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LABEL_COUNT; k++)
        begin
            min_col_reg[k] <= min_col_next[k];
            max_col_reg[k] <= max_col_next[k];
            min_row_reg[k] <= min_row_next[k];
            max_row_reg[k] <= max_row_next[k];
        end
    end

    assign seen = seen_reg;
    assign min_col = min_col_reg;
    assign max_col = max_col_reg;
    assign min_row = min_row_reg;
    assign max_row = max_row_reg;
endmodule

>>> design/lbbt_drain.sv
// end of frame drain sequencer and box output register
module lbbt_drain #(
    parameter int CW = lbbt_pkg::COORD_W_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lbbt_pkg::px_ctrl_t                 px,
    input  logic [lbbt_pkg::LABEL_COUNT-1:0]   seen,
    input  logic [CW-1:0]                      min_col [lbbt_pkg::LABEL_COUNT],
    input  logic [CW-1:0]                      max_col [lbbt_pkg::LABEL_COUNT],
    input  logic [CW-1:0]                      min_row [lbbt_pkg::LABEL_COUNT],
    input  logic [CW-1:0]                      max_row [lbbt_pkg::LABEL_COUNT],
    output lbbt_pkg::drain_ctrl_t              drain,
    lbbt_box_if.source                         boxes
);
    import lbbt_pkg::*;

    localparam int SW = CW + 1;

    logic                   busy_reg, busy_next;
    logic                   valid_reg, valid_next;
    logic [PIXEL_W-1:0]     label_reg;
    logic [CW-1:0]          box_x_reg;
    logic [CW-1:0]          box_y_reg;
    logic [SW-1:0]          box_width_reg;
    logic [SW-1:0]          box_height_reg;
    logic                   found_reg;
    logic                   last_reg;

    logic                   load;
    logic                   any_seen;
    logic [LABEL_IDX_W-1:0] idx;
    logic [LABEL_COUNT-1:0] pick;
    logic                   is_last;

    // lowest seen label goes first
    always_comb
    begin
        idx = '0;
        for (int k = LABEL_COUNT - 1; k >= 0; k--)
        begin
            if (seen[k])
                idx = LABEL_IDX_W'(k);
        end
    end

    assign any_seen = |seen;
    assign pick = seen & (~seen + LABEL_COUNT'(1));
    assign is_last = (seen & ~pick) == '0;
    assign load = busy_reg && (!valid_reg || boxes.ready);

    always_comb
    begin
        busy_next = busy_reg;
        valid_next = valid_reg;
        if (valid_reg && boxes.ready)
            valid_next = 1'b0;
        if (px.valid && px.frame_end)
            busy_next = 1'b1;
        if (load)
        begin
            valid_next = 1'b1;
            if (is_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (any_seen)
            begin
                label_reg <= LABEL_FIRST + PIXEL_W'(idx);
                box_x_reg <= min_col[idx];
                box_y_reg <= min_row[idx];
                box_width_reg <= SW'(max_col[idx]) - SW'(min_col[idx]) + SW'(1);
                box_height_reg <= SW'(max_row[idx]) - SW'(min_row[idx]) + SW'(1);
                found_reg <= 1'b1;
            end
            else
            begin
                label_reg <= LABEL_NONE;
                box_x_reg <= '0;
                box_y_reg <= '0;
                box_width_reg <= '0;
                box_height_reg <= '0;
                found_reg <= 1'b0;
            end
            last_reg <= is_last;
        end
    end

    assign drain.busy = busy_reg;
    assign drain.clear = load ? pick : '0;

    assign boxes.valid = valid_reg;
    assign boxes.label = label_reg;
    assign boxes.box_x = box_x_reg;
    assign boxes.box_y = box_y_reg;
    assign boxes.box_width = box_width_reg;
    assign boxes.box_height = box_height_reg;
    assign boxes.found = found_reg;
    assign boxes.last = last_reg;
endmodule

>>> design/label_bounding_box_tracker_top.sv
// top level of the label bounding box tracker
// Takes one label pixel per clock in raster order, unless held off at a frame end, and tracks
// the extents of labels 201 to 205. The word holding the last pixel of a frame is registered,
// then the store takes it in the next cycle; after that the drain sequencer sends one box per
// seen label, lowest label first, one per cycle through the output register while the output
// is not stalled, or a single empty box when no label was seen. Input pauses after the last
// pixel of a frame while that word is registered and while the drain is busy, so longer while
// the output is stalled; otherwise a pixel is taken every cycle.
`include "label_bounding_box_tracker_top_macros.svh"

module label_bounding_box_tracker_top #(
    parameter int MAX_DIM = lbbt_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [lbbt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lbbt_pkg::CFG_W-1:0]      cfg_data,
    lbbt_pixel_if.sink                      pixels,
    lbbt_box_if.source                      boxes
);
    import lbbt_pkg::*;

    localparam int CW = $clog2(MAX_DIM);

    px_ctrl_t               px;
    drain_ctrl_t            drain;
    logic [PIXEL_W-1:0]     px_pixel;
    logic [CW-1:0]          px_col;
    logic [CW-1:0]          px_row;
    logic [LABEL_COUNT-1:0] seen;
    logic [CW-1:0]          min_col [LABEL_COUNT];
    logic [CW-1:0]          max_col [LABEL_COUNT];
    logic [CW-1:0]          min_row [LABEL_COUNT];
    logic [CW-1:0]          max_row [LABEL_COUNT];

    lbbt_raster #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW)
    ) u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .pixels   (pixels),
        .drain    (drain),
        .px       (px),
        .px_pixel (px_pixel),
        .px_col   (px_col),
        .px_row   (px_row)
    );

    lbbt_store #(
        .CW (CW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .px       (px),
        .px_pixel (px_pixel),
        .px_col   (px_col),
        .px_row   (px_row),
        .drain    (drain),
        .seen     (seen),
        .min_col  (min_col),
        .max_col  (max_col),
        .min_row  (min_row),
        .max_row  (max_row)
    );

    lbbt_drain #(
        .CW (CW)
    ) u_drain (
        .clk     (clk),
        .rst_n   (rst_n),
        .px      (px),
        .seen    (seen),
        .min_col (min_col),
        .max_col (max_col),
        .min_row (min_row),
        .max_row (max_row),
        .drain   (drain),
        .boxes   (boxes)
    );

    `LBBT_ASSERT_SAME(a_no_pixel_in_drain, clk, rst_n, drain.busy, !pixels.ready, "pixel taken during drain")
    `LBBT_ASSERT_NEXT(a_frame_end_starts_drain, clk, rst_n, px.valid && px.frame_end, drain.busy, "drain did not start")
    `LBBT_ASSERT_SAME(a_empty_box_is_last, clk, rst_n, boxes.valid && !boxes.found, boxes.last, "empty box not last")
    `LBBT_ASSERT_SAME(a_store_cleared_after_drain, clk, rst_n, $fell(drain.busy), !(|seen), "store not cleared")
endmodule
